// File: rtl/lkvc_pkg.sv
// Shared constants for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

  // Default number of cache entries.
  localparam int DEPTH_DFLT = 16;

  // Fixed field widths.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity register after reset.
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(16);

  // Operation codes on the kind field.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

endpackage

`default_nettype wire

// File: rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel (in_valid / in_stall): one transaction per access. in_kind selects
// get or put, in_key is the key and in_value the value a put stores.
// Result channel (out_valid / out_stall): one transaction per get, carrying
// out_hit and out_read_value (the stored value, or all ones on a miss). Puts
// return nothing.
// cfg_wr_en / cfg_wr_data set the capacity in use (0 acts as 1, values above
// DEPTH act as DEPTH). Write it only while no access is in flight.
// A get accepted on the input is held in the access register; its result is then
// registered in the result register, which drives out_valid. Throughput: one
// access per cycle unless a get is held by a stalled result channel. The tag compare
// across all entries and the rank update run in one pass between the two registers.
// Reset (rst_n low, synchronous) empties the cache and sets capacity to 16.
// While the receiver stalls with a result pending, a held get stays in the
// access register and stalls the input; puts keep flowing past.
`default_nettype none

module lru_key_value_cache #(
  parameter int DEPTH = lkvc_pkg::DEPTH_DFLT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data,
  // access channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0]  in_key,
  input  wire logic signed [lkvc_pkg::VAL_W-1:0]  in_value,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_hit,
  output logic signed [lkvc_pkg::VAL_W-1:0]       out_read_value
);
  import lkvc_pkg::*;

  localparam int RkW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  // configuration and occupancy
  logic [CAP_W-1:0] cap_r;
  logic [CntW-1:0]  occ_r, occ_nxt;

  // per-entry lanes
  logic                    valid_r [DEPTH];
  logic                    valid_nxt [DEPTH];
  logic [KEY_W-1:0]        key_r [DEPTH];
  logic [VAL_W-1:0]        val_r [DEPTH];
  logic [RkW-1:0]          rank_r [DEPTH];
  logic [RkW-1:0]          rank_nxt [DEPTH];

  // access register
  logic                    st_vld_r;
  logic                    st_kind_r;
  logic [KEY_W-1:0]        st_key_r;
  logic [VAL_W-1:0]        st_val_r;

  // result register
  logic                    out_vld_r;
  logic                    out_hit_r;
  logic [VAL_W-1:0]        out_val_r;

  // lookup
  logic [DEPTH-1:0]        hit_vec, vic_vec, fill_vec, tgt_vec;
  logic                    any_hit, is_put, full, fire, accept;
  logic                    do_promote, wr_key, wr_val;
  logic [VAL_W-1:0]        hit_val;
  logic [CntW-1:0]         hit_rank, tgt_rank;
  logic [CmpW-1:0]         occ_ext, cap_min;

  assign is_put = (st_kind_r == KIND_PUT);
  // A put never touches the result register, so it goes even while stalled.
  assign fire   = st_vld_r && (is_put || !out_vld_r || !out_stall);
  assign in_stall = st_vld_r && !fire;
  assign accept = in_valid && !in_stall;

  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int j = 0; j < DEPTH; j++) begin
      hit_vec[j]  = valid_r[j] && (key_r[j] == st_key_r);
      vic_vec[j]  = valid_r[j] && (CntW'(rank_r[j]) == occ_r - CntW'(1));
      // entries fill in slot order and are never freed, so the free slot is occ_r
      fill_vec[j] = !valid_r[j] && (occ_r == CntW'(j));
      hit_val     = hit_val  | (hit_vec[j] ? val_r[j] : '0);
      hit_rank    = hit_rank | (hit_vec[j] ? CntW'(rank_r[j]) : '0);
    end
    any_hit = |hit_vec;

    occ_ext = CmpW'(occ_r);
    cap_min = (cap_r == '0) ? CmpW'(1) : CmpW'(cap_r);
    full    = (occ_ext >= CmpW'(DEPTH)) || (occ_ext >= cap_min);

    // Every case is a promote of one target: entries ranked below it age by one.
    // A fill uses occ_r as its rank so that all valid entries age.
    if (any_hit) begin
      tgt_vec  = hit_vec;
      tgt_rank = hit_rank;
    end else if (full) begin
      tgt_vec  = vic_vec;
      tgt_rank = occ_r - CntW'(1);
    end else begin
      tgt_vec  = fill_vec;
      tgt_rank = occ_r;
    end

    do_promote = fire && (any_hit || is_put);
    wr_key     = fire && is_put && !any_hit;
    wr_val     = fire && is_put;

    occ_nxt = (wr_key && !full) ? occ_r + CntW'(1) : occ_r;
    for (int j = 0; j < DEPTH; j++) begin
      valid_nxt[j] = valid_r[j];
      rank_nxt[j]  = rank_r[j];
      if (do_promote) begin
        if (tgt_vec[j]) begin
          rank_nxt[j] = '0;
          if (wr_key) begin
            valid_nxt[j] = 1'b1;
          end
        end else if (valid_r[j] && (CntW'(rank_r[j]) < tgt_rank)) begin
          rank_nxt[j] = rank_r[j] + RkW'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RST;
      occ_r     <= '0;
      st_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        valid_r[j] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      occ_r <= occ_nxt;
      for (int j = 0; j < DEPTH; j++) begin
        valid_r[j] <= valid_nxt[j];
      end
      if (accept) begin
        st_vld_r <= 1'b1;
      end else if (fire) begin
        st_vld_r <= 1'b0;
      end
      if (fire && !is_put) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      st_kind_r <= in_kind;
      st_key_r  <= in_key;
      st_val_r  <= in_value;
    end
    if (fire && !is_put) begin
      out_hit_r <= any_hit;
      out_val_r <= any_hit ? hit_val : MISS_VALUE;
    end
    for (int j = 0; j < DEPTH; j++) begin
      rank_r[j] <= rank_nxt[j];
      if (tgt_vec[j] && wr_key) begin
        key_r[j] <= st_key_r;
      end
      if (tgt_vec[j] && wr_val) begin
        val_r[j] <= st_val_r;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;

  // keys are unique, so at most one entry matches
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    st_vld_r |-> $onehot0(hit_vec))
    else $error("more than one entry matches the key");

  a_victim_one: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_put && !any_hit && full) |-> $onehot(vic_vec))
    else $error("no unique least recent entry on eviction");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(DEPTH))
    else $error("occupancy beyond depth");

  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !is_put && !any_hit) |=> (out_valid && !out_hit && out_read_value == MISS_VALUE))
    else $error("miss result not returned as all ones");

endmodule

`default_nettype wire
